[design/aeg_pkg.sv]
// Shared types, constants and a helper function for the ADSR envelope gain block.
package aeg_pkg;

	// Field widths.
	localparam int TIME_BITS_DEF = 24;
	localparam int LEN_W = 16;
	localparam int GAIN_W = 17;
	localparam int QUO_W = 17;
	localparam int PROD_W = GAIN_W + LEN_W;

	// Full scale gain in unsigned Q16.
	localparam logic [GAIN_W-1:0] Q16_ONE = 17'h10000;

	// Configuration port.
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN = 4'd3;

	// Register values after reset.
	localparam logic [LEN_W-1:0] ATTACK_LEN_RST = 16'd2205;
	localparam logic [LEN_W-1:0] DECAY_LEN_RST = 16'd3087;
	localparam logic [GAIN_W-1:0] SUSTAIN_LEVEL_RST = 17'd26214;
	localparam logic [LEN_W-1:0] RELEASE_LEN_RST = 16'd4410;

	// The divider resolves QUO_W quotient bits over DIV_STAGES stages.
	localparam int DIV_STAGES = 5;

	// Quotient bits resolved in divider stage k (4 + 4 + 3 + 3 + 3 = 17).
	function automatic int div_steps(input int k);
		return (k < 2) ? 4 : 3;
	endfunction

	// Envelope segment that a word falls into.
	typedef enum logic [2:0] {
		SEG_ZERO,
		SEG_ATTACK,
		SEG_DECAY,
		SEG_SUSTAIN,
		SEG_RELEASE
	} seg_t;

	// Word moving through the divider stages.
	typedef struct packed {
		seg_t                seg;
		logic [GAIN_W-1:0]   level;
		logic [LEN_W-1:0]    divisor;
		logic [LEN_W-1:0]    rem;
		logic [QUO_W-1:0]    bits;
		logic [QUO_W-1:0]    quo;
	} div_word_t;

endpackage

[design/adsr_envelope_gain.sv]
// Each word passes in order through three front stages, five divider stages and the
// output register; each of them holds one word, and each stage advances on its own.
// Throughput: one word per cycle while out_stall does not hold the pipeline.
// The 17-bit quotient is resolved 3 to 4 bits per divider stage.
// Reset clears all valid bits and loads the register defaults.
module adsr_envelope_gain #(
	parameter int TIME_BITS = aeg_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [aeg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aeg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [TIME_BITS-1:0]             time_since_start,
	input  logic [TIME_BITS-1:0]             note_len,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [aeg_pkg::GAIN_W-1:0]       gain
);

	localparam int NS = aeg_pkg::DIV_STAGES;
	localparam int LW = aeg_pkg::LEN_W;
	localparam int GW = aeg_pkg::GAIN_W;

	// Configuration registers.
	logic [LW-1:0] attack_len_q, decay_len_q, release_len_q;
	logic [GW-1:0] sustain_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q <= aeg_pkg::ATTACK_LEN_RST;
			decay_len_q <= aeg_pkg::DECAY_LEN_RST;
			sustain_level_q <= aeg_pkg::SUSTAIN_LEVEL_RST;
			release_len_q <= aeg_pkg::RELEASE_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				aeg_pkg::REG_ATTACK_LEN: attack_len_q <= cfg_wdata[LW-1:0];
				aeg_pkg::REG_DECAY_LEN: decay_len_q <= cfg_wdata[LW-1:0];
				aeg_pkg::REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_wdata[GW-1:0];
				aeg_pkg::REG_RELEASE_LEN: release_len_q <= cfg_wdata[LW-1:0];
				default: ;
			endcase
		end
	end

	// Chain of divider words; entry 0 comes from the front stages.
	logic                dv   [NS+1];
	logic                dadv [NS+1];
	aeg_pkg::div_word_t  dw   [NS+1];

	aeg_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.time_since_start(time_since_start),
		.note_len(note_len),
		.attack_len(attack_len_q),
		.decay_len(decay_len_q),
		.sustain_level(sustain_level_q),
		.release_len(release_len_q),
		.out_adv(dadv[0]),
		.out_valid(dv[0]),
		.out_word(dw[0])
	);

	for (genvar k = 0; k < NS; k++) begin : g_div
		aeg_div_stage #(
			.STEPS(aeg_pkg::div_steps(k))
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(dv[k]),
			.in_word(dw[k]),
			.in_adv(dadv[k]),
			.out_adv(dadv[k+1]),
			.out_valid(dv[k+1]),
			.out_word(dw[k+1])
		);
	end

	// Output register; it takes a new word when empty or when the word is taken.
	logic          out_valid_q;
	logic [GW-1:0] gain_q;
	logic [GW-1:0] gain_c;

	assign dadv[NS] = !out_valid_q || !out_stall;

	// Map the quotient to the gain of its segment.
	always_comb begin
		case (dw[NS].seg)
			aeg_pkg::SEG_ATTACK: gain_c = dw[NS].quo;
			aeg_pkg::SEG_DECAY: gain_c = aeg_pkg::Q16_ONE - dw[NS].quo;
			aeg_pkg::SEG_SUSTAIN: gain_c = dw[NS].level;
			aeg_pkg::SEG_RELEASE: gain_c = dw[NS].quo;
			default: gain_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dadv[NS]) begin
			out_valid_q <= dv[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (dadv[NS] && dv[NS]) begin
			gain_q <= gain_c;
		end
	end

	assign out_valid = out_valid_q;
	assign gain = gain_q;

endmodule

[design/aeg_front.sv]
// Front pipeline: segment boundaries, segment decision and the gain product.
module aeg_front #(
	parameter int TIME_BITS = aeg_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [TIME_BITS-1:0]         time_since_start,
	input  logic [TIME_BITS-1:0]         note_len,
	input  logic [aeg_pkg::LEN_W-1:0]    attack_len,
	input  logic [aeg_pkg::LEN_W-1:0]    decay_len,
	input  logic [aeg_pkg::GAIN_W-1:0]   sustain_level,
	input  logic [aeg_pkg::LEN_W-1:0]    release_len,
	input  logic                         out_adv,
	output logic                         out_valid,
	output aeg_pkg::div_word_t           out_word
);

	localparam int CW = TIME_BITS + 2;
	localparam int LW = aeg_pkg::LEN_W;
	localparam int GW = aeg_pkg::GAIN_W;

	// Stage registers.
	logic                  valid_s1, valid_s2, valid_s3;
	logic [TIME_BITS-1:0]  t_s1, len_s1;
	logic [LW:0]           ad_s1;
	logic [TIME_BITS:0]    lr_s1;
	aeg_pkg::seg_t         seg_s2;
	logic [GW-1:0]         mx_s2, level_s2;
	logic [LW-1:0]         my_s2, divisor_s2;
	aeg_pkg::div_word_t    word_s3;

	// Per-stage advance: a stage loads when it is empty or its word moves on.
	logic adv1, adv2, adv3;
	assign adv3 = !valid_s3 || out_adv;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign in_stall = !adv1;

	// Stage 2 comparisons on a common signed width.
	logic signed [CW-1:0] t_ext, a_ext, ad_ext, len_ext, lr_ext;
	logic                 lt_a, lt_ad, lt_len, lt_lr;
	logic [GW-1:0]        s_sat;
	aeg_pkg::seg_t        seg_c;
	logic [GW-1:0]        mx_c;
	logic [LW-1:0]        my_c, divisor_c;

	assign t_ext   = {{2{t_s1[TIME_BITS-1]}}, t_s1};
	assign a_ext   = {{(CW-LW){1'b0}}, attack_len};
	assign ad_ext  = {{(CW-LW-1){1'b0}}, ad_s1};
	assign len_ext = {2'b00, len_s1};
	assign lr_ext  = {1'b0, lr_s1};

	assign lt_a   = t_ext < a_ext;
	assign lt_ad  = t_ext < ad_ext;
	assign lt_len = t_ext < len_ext;
	assign lt_lr  = t_ext < lr_ext;

	// Sustain above full scale saturates.
	assign s_sat = (sustain_level > aeg_pkg::Q16_ONE) ? aeg_pkg::Q16_ONE : sustain_level;

	// Segment decision and multiplier operands. Within a segment the offsets fit
	// in 16 bits, so the low bits of each difference are exact.
	always_comb begin
		seg_c = aeg_pkg::SEG_ZERO;
		mx_c = '0;
		my_c = '0;
		divisor_c = '0;
		if (t_s1[TIME_BITS-1]) begin
			seg_c = aeg_pkg::SEG_ZERO;
		end else if (lt_a) begin
			seg_c = aeg_pkg::SEG_ATTACK;
			mx_c = aeg_pkg::Q16_ONE;
			my_c = t_s1[LW-1:0];
			divisor_c = attack_len;
		end else if (lt_ad) begin
			seg_c = aeg_pkg::SEG_DECAY;
			mx_c = aeg_pkg::Q16_ONE - s_sat;
			my_c = t_s1[LW-1:0] - attack_len;
			divisor_c = decay_len;
		end else if (lt_len) begin
			seg_c = aeg_pkg::SEG_SUSTAIN;
		end else if (lt_lr) begin
			seg_c = aeg_pkg::SEG_RELEASE;
			mx_c = s_sat;
			my_c = lr_s1[LW-1:0] - t_s1[LW-1:0];
			divisor_c = release_len;
		end else begin
			seg_c = aeg_pkg::SEG_ZERO;
		end
	end

	// Stage 3 product, split into the divider's starting remainder and bits.
	logic [aeg_pkg::PROD_W-1:0] prod;
	assign prod = {{LW{1'b0}}, mx_s2} * {{GW{1'b0}}, my_s2};

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: register the word with the boundary sums.
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			t_s1 <= time_since_start;
			len_s1 <= note_len;
			ad_s1 <= {1'b0, attack_len} + {1'b0, decay_len};
			lr_s1 <= {1'b0, note_len} + {{(TIME_BITS+1-LW){1'b0}}, release_len};
		end
	end

	// Stage 2: segment and operands.
	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			seg_s2 <= seg_c;
			mx_s2 <= mx_c;
			my_s2 <= my_c;
			divisor_s2 <= divisor_c;
			level_s2 <= s_sat;
		end
	end

	// Stage 3: product loaded into the divider word.
	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			word_s3.seg <= seg_s2;
			word_s3.level <= level_s2;
			word_s3.divisor <= divisor_s2;
			word_s3.rem <= prod[aeg_pkg::PROD_W-1:aeg_pkg::QUO_W];
			word_s3.bits <= prod[aeg_pkg::QUO_W-1:0];
			word_s3.quo <= '0;
		end
	end

	assign out_valid = valid_s3;
	assign out_word = word_s3;

endmodule

[design/aeg_div_stage.sv]
// One stage of the restoring divider, resolving STEPS quotient bits.
module aeg_div_stage #(
	parameter int STEPS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  aeg_pkg::div_word_t  in_word,
	output logic                in_adv,
	input  logic                out_adv,
	output logic                out_valid,
	output aeg_pkg::div_word_t  out_word
);

	localparam int LW = aeg_pkg::LEN_W;
	localparam int QW = aeg_pkg::QUO_W;

	logic                valid_sd;
	aeg_pkg::div_word_t  word_sd;
	aeg_pkg::div_word_t  next_w;
	logic [LW:0]         trial;
	logic [LW:0]         diff;

	assign in_adv = !valid_sd || out_adv;

	// Shift in one dividend bit per step and subtract the divisor when it fits.
	always_comb begin
		next_w = in_word;
		trial = '0;
		diff = '0;
		for (int i = 0; i < STEPS; i++) begin
			trial = {next_w.rem, next_w.bits[QW-1]};
			diff = trial - {1'b0, next_w.divisor};
			next_w.bits = {next_w.bits[QW-2:0], 1'b0};
			if (trial >= {1'b0, next_w.divisor}) begin
				next_w.rem = diff[LW-1:0];
				next_w.quo = {next_w.quo[QW-2:0], 1'b1};
			end else begin
				next_w.rem = trial[LW-1:0];
				next_w.quo = {next_w.quo[QW-2:0], 1'b0};
			end
		end
	end

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else if (in_adv) begin
			valid_sd <= in_valid;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (in_adv && in_valid) begin
			word_sd <= next_w;
		end
	end

	assign out_valid = valid_sd;
	assign out_word = word_sd;

endmodule

[test/envelope_gain_checker.sv]
// Watches both channels of the envelope gain block, predicts each gain and compares it.
`timescale 1ns / 1ps

module envelope_gain_checker #(
	parameter int TIME_BITS = aeg_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aeg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aeg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [TIME_BITS-1:0]          time_since_start,
	input  logic [TIME_BITS-1:0]          note_len,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [aeg_pkg::GAIN_W-1:0]     gain,
	output int                            mismatches,
	output int                            outstanding
);

	// Shadow copy of the envelope registers.
	logic [aeg_pkg::LEN_W-1:0]  attack_q;
	logic [aeg_pkg::LEN_W-1:0]  decay_q;
	logic [aeg_pkg::GAIN_W-1:0] sustain_q;
	logic [aeg_pkg::LEN_W-1:0]  release_q;

	// Gains predicted for accepted words, oldest first.
	logic [aeg_pkg::GAIN_W-1:0] expected_gains [$];
	logic [aeg_pkg::GAIN_W-1:0] oldest_gain;

	// Piecewise-linear envelope at one sample time, quotients truncated.
	function automatic logic [aeg_pkg::GAIN_W-1:0] envelope_gain(
			input logic [TIME_BITS-1:0] t_raw,
			input logic [TIME_BITS-1:0] len_raw);
		longint t;
		longint len;
		longint a;
		longint d;
		longint r;
		longint s;
		longint one;
		longint span;
		longint g;
		t = $signed(t_raw);
		len = len_raw;
		a = attack_q;
		d = decay_q;
		r = release_q;
		s = sustain_q;
		one = aeg_pkg::Q16_ONE;
		// Sustain levels above full scale are clipped.
		if (s > one)
			s = one;
		if (t < 0)
			g = 0;
		else if (t < a)
			g = (t * one) / a;
		else if (t - a < d)
			g = one - ((one - s) * (t - a)) / d;
		else begin
			// The sustain span goes negative for notes shorter than attack plus decay.
			t = t - a - d;
			span = len - a - d;
			if (t < span)
				g = s;
			else if (t - span < r)
				g = (s * (r - (t - span))) / r;
			else
				g = 0;
		end
		return g[aeg_pkg::GAIN_W-1:0];
	endfunction

	// Predict on every accepted input word, check every accepted gain word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q = aeg_pkg::ATTACK_LEN_RST;
			decay_q = aeg_pkg::DECAY_LEN_RST;
			sustain_q = aeg_pkg::SUSTAIN_LEVEL_RST;
			release_q = aeg_pkg::RELEASE_LEN_RST;
			expected_gains.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_gains.push_back(envelope_gain(time_since_start, note_len));
			if (out_valid && !out_stall) begin
				if (expected_gains.size() == 0) begin
					$error("gain %0d arrived with no word pending", gain);
					mismatches <= mismatches + 1;
				end else begin
					oldest_gain = expected_gains.pop_front();
					if (gain !== oldest_gain) begin
						$error("gain mismatch: expected %0d, actual %0d", oldest_gain, gain);
						mismatches <= mismatches + 1;
					end
				end
			end
			// Register writes take effect for words accepted after this edge.
			if (cfg_we) begin
				case (cfg_index)
					aeg_pkg::REG_ATTACK_LEN: attack_q = cfg_wdata[aeg_pkg::LEN_W-1:0];
					aeg_pkg::REG_DECAY_LEN: decay_q = cfg_wdata[aeg_pkg::LEN_W-1:0];
					aeg_pkg::REG_SUSTAIN_LEVEL: sustain_q = cfg_wdata[aeg_pkg::GAIN_W-1:0];
					aeg_pkg::REG_RELEASE_LEN: release_q = cfg_wdata[aeg_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			outstanding <= expected_gains.size();
		end
	end

endmodule

[test/tb.sv]
// Top of the envelope gain testbench: clock, reset, stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb;

	localparam int TB_TIME = aeg_pkg::TIME_BITS_DEF;
	localparam int NUM_PHASES = 6;
	localparam int WORDS_PER_PHASE = 100;
	localparam int HOLD_PHASE = 2;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int LEN_MAX = 65535;
	localparam logic [aeg_pkg::CFG_IDX_W-1:0] FIRST_SPARE_REG = aeg_pkg::REG_RELEASE_LEN + 1'b1;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_RUNS
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [aeg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [aeg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [TB_TIME-1:0] time_since_start = '0;
	logic [TB_TIME-1:0] note_len = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [aeg_pkg::GAIN_W-1:0] gain;
	logic hold_req = 1'b0;

	int mismatch_total;
	int gains_outstanding;
	int quiet_cycles = 0;

	// Register values last written, used only to aim the stimulus.
	int cur_attack;
	int cur_decay;
	int cur_release;

	// Receiver stall pattern state.
	stall_mode_t stall_mode = STALL_NONE;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_used = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	adsr_envelope_gain u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.time_since_start(time_since_start),
		.note_len(note_len),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gain(gain)
	);

	envelope_gain_checker #(.TIME_BITS(TB_TIME)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.time_since_start(time_since_start),
		.note_len(note_len),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gain(gain),
		.mismatches(mismatch_total),
		.outstanding(gains_outstanding)
	);

	// Receiver stalls: one long hold-off on request, otherwise a changing random pattern.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_req && !hold_used) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(8, 80);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
				default: if ($urandom_range(0, 5) == 0) out_stall <= !out_stall;
			endcase
		end
	end

	// Watchdog: too long without any word moving on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offer one word and return once it has been accepted.
	task automatic send_word(input logic [TB_TIME-1:0] t, input logic [TB_TIME-1:0] l);
		in_valid <= 1'b1;
		time_since_start <= t;
		note_len <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted gain has come back.
	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (gains_outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [aeg_pkg::CFG_IDX_W-1:0] idx,
			input logic [aeg_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Load all four registers; the spare bit of the 16-bit ones is random and must be dropped.
	task automatic set_envelope(input int a, input int d, input int s, input int r);
		write_reg(aeg_pkg::REG_ATTACK_LEN, {$urandom_range(0, 1) == 1, a[15:0]});
		write_reg(aeg_pkg::REG_DECAY_LEN, {$urandom_range(0, 1) == 1, d[15:0]});
		write_reg(aeg_pkg::REG_SUSTAIN_LEVEL, s[16:0]);
		write_reg(aeg_pkg::REG_RELEASE_LEN, {$urandom_range(0, 1) == 1, r[15:0]});
		// A write beyond the register list must change nothing.
		write_reg(aeg_pkg::CFG_IDX_W'($urandom_range(FIRST_SPARE_REG,
				2**aeg_pkg::CFG_IDX_W - 1)), aeg_pkg::CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		cur_attack = a & LEN_MAX;
		cur_decay = d & LEN_MAX;
		cur_release = r & LEN_MAX;
	endtask

	function automatic int pick_len();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return LEN_MAX;
			2: return $urandom_range(1, 8);
			3: return $urandom_range(0, LEN_MAX);
			default: return $urandom_range(1, 4000);
		endcase
	endfunction

	function automatic int pick_sustain();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return aeg_pkg::Q16_ONE;
			2: return $urandom_range(aeg_pkg::Q16_ONE + 1, 2**aeg_pkg::GAIN_W - 1);
			default: return $urandom_range(0, aeg_pkg::Q16_ONE);
		endcase
	endfunction

	// Mostly times aimed at segment edges and inside the note, some negative or raw noise.
	task automatic send_random_word();
		longint a;
		longint d;
		longint r;
		longint l;
		longint base;
		longint t;
		int jitter;
		logic [TB_TIME-1:0] lv;
		logic [TB_TIME-1:0] tv;
		a = cur_attack;
		d = cur_decay;
		r = cur_release;
		case ($urandom_range(0, 5))
			0: l = $urandom_range(0, a + d);
			1: begin
				lv = TB_TIME'($urandom);
				l = lv;
			end
			default: l = a + d + $urandom_range(0, 3000);
		endcase
		lv = l[TB_TIME-1:0];
		l = lv;
		case ($urandom_range(0, 9))
			0: begin
				jitter = $urandom_range(1, 5000);
				t = -jitter;
			end
			1: begin
				tv = TB_TIME'($urandom);
				t = tv;
			end
			2, 3, 4: begin
				case ($urandom_range(0, 4))
					0: base = 0;
					1: base = a;
					2: base = a + d;
					3: base = l;
					default: base = l + r;
				endcase
				jitter = $urandom_range(0, 4);
				t = base + jitter - 2;
			end
			default: t = $urandom_range(0, l + r + 50);
		endcase
		send_word(t[TB_TIME-1:0], lv);
	endtask

	initial begin
		int sent;
		int burst;
		int gap;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words against the reset envelope, note length 10000.
		cur_attack = aeg_pkg::ATTACK_LEN_RST;
		cur_decay = aeg_pkg::DECAY_LEN_RST;
		cur_release = aeg_pkg::RELEASE_LEN_RST;
		send_word(24'h800000, 24'd10000);
		send_word(24'hFFFFFF, 24'd10000);
		send_word(24'd0, 24'd10000);
		send_word(24'd1, 24'd10000);
		send_word(24'd2204, 24'd10000);
		send_word(24'd2205, 24'd10000);
		send_word(24'd5291, 24'd10000);
		send_word(24'd5292, 24'd10000);
		send_word(24'd7000, 24'd10000);
		send_word(24'd9999, 24'd10000);
		send_word(24'd10000, 24'd10000);
		send_word(24'd14409, 24'd10000);
		send_word(24'd14410, 24'd10000);
		send_word(24'h7FFFFF, 24'd10000);
		// Notes shorter than attack plus decay, and the longest note.
		send_word(24'd3000, 24'd0);
		send_word(24'd5400, 24'd100);
		send_word(24'd100000, 24'hFFFFFF);
		send_word(24'h7FFFFF, 24'hFFFFFF);
		wait_results();

		// Zero-length segments and a sustain level above full scale.
		set_envelope(0, 0, 2**aeg_pkg::GAIN_W - 1, 0);
		send_word(24'd0, 24'd0);
		send_word(24'd1, 24'd0);
		send_word(24'd4, 24'd5);
		send_word(24'd5, 24'd5);
		send_word(24'h800000, 24'd0);
		wait_results();

		// Random phases, each with its own envelope; the first two take the extremes.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 0)
				set_envelope(LEN_MAX, LEN_MAX, aeg_pkg::Q16_ONE, LEN_MAX);
			else if (p == 1)
				set_envelope(0, 0, 0, 0);
			else
				set_envelope(pick_len(), pick_len(), pick_sustain(), pick_len());
			if (p == HOLD_PHASE)
				hold_req <= 1'b1;
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				burst = $urandom_range(1, 40);
				for (int k = 0; k < burst && sent < WORDS_PER_PHASE; k++) begin
					send_random_word();
					sent++;
				end
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			wait_results();
		end

		// Let any stray gain word show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_total == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
